FILE: rtl/fcmr_pkg.sv
// ----------------------------------------------------------------------------
// fcmr_pkg
// Shared constants, register codes and interface structs for the int8
// fully connected multiply-accumulate and requantization block.
// ----------------------------------------------------------------------------
package fcmr_pkg;

    localparam int LANES        = 4;
    localparam int PACKED_LANES = 4;
    localparam int BYTE_W       = 8;
    localparam int LANE_DATA_W  = PACKED_LANES * BYTE_W;
    localparam int LANES_USED_W = 3;

    // (a - act_zero) * w fits comfortably in 17 signed bits
    localparam int PROD_W  = 17;
    localparam int SUM_W   = PROD_W + $clog2(LANES);
    localparam int ACC_W   = 32;
    localparam int MULT_W  = 31;
    localparam int SHIFT_W = 6;
    localparam int PRODUCT_W = ACC_W + MULT_W - 1;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [BYTE_W-1:0] ACT_ZERO_RST   = 8'h00;
    localparam logic [BYTE_W-1:0] OUT_ZERO_RST   = 8'h00;
    localparam logic [BYTE_W-1:0] CLAMP_LOW_RST  = 8'h80;
    localparam logic [BYTE_W-1:0] CLAMP_HIGH_RST = 8'h7F;

    localparam int OUT_MIN = -128;
    localparam int OUT_MAX = 127;

    typedef enum logic [1:0] {
        REG_ACT_ZERO   = 2'd0,
        REG_OUT_ZERO   = 2'd1,
        REG_CLAMP_LOW  = 2'd2,
        REG_CLAMP_HIGH = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [ACC_W-1:0]   acc;
        logic [MULT_W-1:0]  mult;
        logic [SHIFT_W-1:0] shift;
    } rq_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_zero;
        logic [BYTE_W-1:0] clamp_low;
        logic [BYTE_W-1:0] clamp_high;
    } rq_cfg_t;

endpackage

FILE: rtl/fcmr_lane.sv
// ----------------------------------------------------------------------------
// fcmr_lane
// One multiply lane: subtracts the activation zero point from a signed
// activation byte, multiplies by the signed weight byte, registers the product.
// ----------------------------------------------------------------------------
module fcmr_lane (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic                                  active,
    input  logic [fcmr_pkg::BYTE_W-1:0]           act_byte,
    input  logic [fcmr_pkg::BYTE_W-1:0]           weight_byte,
    input  logic [fcmr_pkg::BYTE_W-1:0]           act_zero,
    output logic signed [fcmr_pkg::PROD_W-1:0]    prod_reg
);
    import fcmr_pkg::*;

    logic signed [PROD_W-1:0] a_ext;
    logic signed [PROD_W-1:0] z_ext;
    logic signed [PROD_W-1:0] w_ext;
    logic signed [PROD_W-1:0] diff;
    logic signed [PROD_W-1:0] prod_next;

    always_comb
    begin
        a_ext = PROD_W'($signed(act_byte));
        z_ext = PROD_W'($signed(act_zero));
        w_ext = PROD_W'($signed(weight_byte));
        diff  = a_ext - z_ext;
        // inactive lanes contribute nothing
        prod_next = active ? PROD_W'(diff * w_ext) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

FILE: rtl/fcmr_requant.sv
// ----------------------------------------------------------------------------
// fcmr_requant
// Four-stage requantization pipeline: magnitude, Q31 multiply, rounding
// shift, then output zero point, saturation and clamping into the result.
// ----------------------------------------------------------------------------
module fcmr_requant (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  fcmr_pkg::rq_req_t             req,
    input  fcmr_pkg::rq_cfg_t             cfg,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fcmr_pkg::BYTE_W-1:0]   result
);
    import fcmr_pkg::*;

    localparam int SUM63_W = PRODUCT_W + 1;
    localparam int TOT_W   = SHIFT_W + 1;
    localparam int V_W     = ACC_W + 2;
    localparam logic signed [V_W-1:0] V_MIN = V_W'(OUT_MIN);
    localparam logic signed [V_W-1:0] V_MAX = V_W'(OUT_MAX);

    // stage 3: magnitude
    logic               mag_valid_reg;
    logic [ACC_W-1:0]   mag_reg;
    logic               mag_neg_reg;
    logic [MULT_W-1:0]  mag_mult_reg;
    logic [SHIFT_W-1:0] mag_shift_reg;

    // stage 4: product
    logic                 prod_valid_reg;
    logic [PRODUCT_W-1:0] prod_reg;
    logic                 prod_neg_reg;
    logic [SHIFT_W-1:0]   prod_shift_reg;

    // stage 5: rounded quotient
    logic             q_valid_reg;
    logic [ACC_W-1:0] q_reg;
    logic             q_neg_reg;

    // stage 6: output
    logic              out_valid_reg;
    logic [BYTE_W-1:0] result_reg;

    logic rdy_out;
    logic rdy_q;
    logic rdy_prod;
    logic rdy_mag;

    logic [ACC_W-1:0]     mag_next;
    logic [PRODUCT_W-1:0] prod_next;
    logic [ACC_W-1:0]     q_next;
    logic [BYTE_W-1:0]    result_next;

    assign rdy_out   = !out_valid_reg || out_ready;
    assign rdy_q     = !q_valid_reg || rdy_out;
    assign rdy_prod  = !prod_valid_reg || rdy_q;
    assign rdy_mag   = !mag_valid_reg || rdy_prod;
    assign req_ready = rdy_mag;

    assign mag_next  = req.acc[ACC_W-1] ? (~req.acc + ACC_W'(1)) : req.acc;
    assign prod_next = PRODUCT_W'(mag_reg) * PRODUCT_W'(mag_mult_reg);

    always_comb
    begin
        logic [TOT_W-1:0]   tot;
        logic [SUM63_W-1:0] rsum;
        tot  = TOT_W'(31) + TOT_W'(prod_shift_reg);
        rsum = {1'b0, prod_reg} + (SUM63_W'(1) << (tot - TOT_W'(1)));
        // shifts of 64 or more leave nothing
        if (tot[TOT_W-1])
        begin
            q_next = '0;
        end
        else
        begin
            q_next = ACC_W'(rsum >> tot);
        end
    end

    always_comb
    begin
        logic signed [V_W-1:0] qs;
        logic signed [V_W-1:0] v;
        logic signed [V_W-1:0] lo;
        logic signed [V_W-1:0] hi;
        qs = $signed({2'b00, q_reg});
        if (q_neg_reg)
        begin
            qs = -qs;
        end
        v  = qs + V_W'($signed(cfg.out_zero));
        lo = V_W'($signed(cfg.clamp_low));
        hi = V_W'($signed(cfg.clamp_high));
        if (v < V_MIN)
        begin
            v = V_MIN;
        end
        if (v > V_MAX)
        begin
            v = V_MAX;
        end
        // lower bound first, upper bound wins when the two cross
        if (v < lo)
        begin
            v = lo;
        end
        if (v > hi)
        begin
            v = hi;
        end
        result_next = BYTE_W'(v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            q_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rdy_mag)
            begin
                mag_valid_reg <= req_valid;
            end
            if (rdy_prod)
            begin
                prod_valid_reg <= mag_valid_reg;
            end
            if (rdy_q)
            begin
                q_valid_reg <= prod_valid_reg;
            end
            if (rdy_out)
            begin
                out_valid_reg <= q_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_mag && req_valid)
        begin
            mag_reg       <= mag_next;
            mag_neg_reg   <= req.acc[ACC_W-1];
            mag_mult_reg  <= req.mult;
            mag_shift_reg <= req.shift;
        end
        if (rdy_prod && mag_valid_reg)
        begin
            prod_reg       <= prod_next;
            prod_neg_reg   <= mag_neg_reg;
            prod_shift_reg <= mag_shift_reg;
        end
        if (rdy_q && prod_valid_reg)
        begin
            q_reg     <= q_next;
            q_neg_reg <= prod_neg_reg;
        end
        if (rdy_out && q_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

FILE: rtl/int8_fully_connected_mac_requant.sv
// path: a result for the input transfer that carries last passes the lane, accumulator,
// magnitude, product, quotient and output registers; a stall on the output side holds it
// throughput: one input item per cycle unless the output stalls; lane products, accumulator
// update, magnitude, Q31 multiply, rounding shift, output clamp: one pipeline stage each
// reset: rst_n clears all valid flags and the accumulator, config registers take reset values
// ----------------------------------------------------------------------------
// int8_fully_connected_mac_requant
// Parallel int8 MAC lanes feeding a wrapping int32 accumulator, followed by
// fixed-point requantization to a clamped int8 output.
// ----------------------------------------------------------------------------
module int8_fully_connected_mac_requant (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [fcmr_pkg::LANE_DATA_W-1:0]    act_lanes,
    input  logic [fcmr_pkg::LANE_DATA_W-1:0]    weight_lanes,
    input  logic [fcmr_pkg::LANES_USED_W-1:0]   lanes_used,
    input  logic                                first,
    input  logic                                last,
    input  logic signed [fcmr_pkg::ACC_W-1:0]   bias,
    input  logic [fcmr_pkg::MULT_W-1:0]         scale_mult,
    input  logic [fcmr_pkg::SHIFT_W-1:0]        scale_shift,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [fcmr_pkg::BYTE_W-1:0]  result,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fcmr_pkg::ADDR_W-1:0]         paddr,
    input  logic [fcmr_pkg::DATA_W-1:0]         pwdata,
    output logic [fcmr_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import fcmr_pkg::*;

    // configuration registers
    logic [BYTE_W-1:0] act_zero_reg;
    logic [BYTE_W-1:0] out_zero_reg;
    logic [BYTE_W-1:0] clamp_low_reg;
    logic [BYTE_W-1:0] clamp_high_reg;
    cfg_reg_t          cfg_sel;
    logic              cfg_wr;

    // stage 1: lane products
    logic               s1_valid_reg;
    logic               s1_first_reg;
    logic               s1_last_reg;
    logic [ACC_W-1:0]   s1_bias_reg;
    logic [MULT_W-1:0]  s1_mult_reg;
    logic [SHIFT_W-1:0] s1_shift_reg;
    logic               s1_load;
    logic               s1_go;
    logic signed [PROD_W-1:0] lane_prod [LANES];
    logic [LANES-1:0]   lane_on;

    // stage 2: accumulator and requant request
    logic             s2_valid_reg;
    rq_req_t          s2_req_reg;
    logic             s2_ready;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic signed [SUM_W-1:0] lane_sum;

    logic    rq_ready;
    rq_cfg_t rq_cfg;
    logic [BYTE_W-1:0] rq_result;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_zero_reg   <= ACT_ZERO_RST;
            out_zero_reg   <= OUT_ZERO_RST;
            clamp_low_reg  <= CLAMP_LOW_RST;
            clamp_high_reg <= CLAMP_HIGH_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_ACT_ZERO:   act_zero_reg   <= pwdata[BYTE_W-1:0];
                REG_OUT_ZERO:   out_zero_reg   <= pwdata[BYTE_W-1:0];
                REG_CLAMP_LOW:  clamp_low_reg  <= pwdata[BYTE_W-1:0];
                REG_CLAMP_HIGH: clamp_high_reg <= pwdata[BYTE_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_ACT_ZERO:   prdata = DATA_W'(act_zero_reg);
            REG_OUT_ZERO:   prdata = DATA_W'(out_zero_reg);
            REG_CLAMP_LOW:  prdata = DATA_W'(clamp_low_reg);
            REG_CLAMP_HIGH: prdata = DATA_W'(clamp_high_reg);
        endcase
    end

    // ---------------- stage 1: lanes ----------------
    assign s1_go    = s1_valid_reg && s2_ready;
    assign in_ready = !s1_valid_reg || s2_ready;
    assign s1_load  = in_valid && in_ready;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        logic [BYTE_W-1:0] act_b;
        logic [BYTE_W-1:0] wgt_b;

        // lane counts above LANES saturate through this compare
        assign lane_on[i] = (32'(lanes_used) > i);

        if (i < PACKED_LANES)
        begin : g_packed
            assign act_b = act_lanes[BYTE_W*i +: BYTE_W];
            assign wgt_b = weight_lanes[BYTE_W*i +: BYTE_W];
        end
        else
        begin : g_empty
            assign act_b = '0;
            assign wgt_b = '0;
        end

        fcmr_lane u_lane (
            .clk         (clk),
            .en          (s1_load),
            .active      (lane_on[i]),
            .act_byte    (act_b),
            .weight_byte (wgt_b),
            .act_zero    (act_zero_reg),
            .prod_reg    (lane_prod[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_first_reg <= first;
            s1_last_reg  <= last;
            s1_bias_reg  <= bias;
            s1_mult_reg  <= scale_mult;
            s1_shift_reg <= scale_shift;
        end
    end

    // ---------------- stage 2: merge and accumulate ----------------
    always_comb
    begin
        lane_sum = '0;
        for (int i = 0; i < LANES; i++)
        begin
            lane_sum = lane_sum + SUM_W'(lane_prod[i]);
        end
    end

    // wraps modulo 2^32
    assign acc_next = (s1_first_reg ? s1_bias_reg : acc_reg) + ACC_W'(lane_sum);
    assign s2_ready = !s2_valid_reg || rq_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_go)
            begin
                acc_reg <= acc_next;
            end
            // items without last end here
            if (s2_ready)
            begin
                s2_valid_reg <= s1_go && s1_last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            s2_req_reg.acc   <= acc_next;
            s2_req_reg.mult  <= s1_mult_reg;
            s2_req_reg.shift <= s1_shift_reg;
        end
    end

    // ---------------- requantization ----------------
    assign rq_cfg.out_zero   = out_zero_reg;
    assign rq_cfg.clamp_low  = clamp_low_reg;
    assign rq_cfg.clamp_high = clamp_high_reg;

    fcmr_requant u_requant (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s2_valid_reg),
        .req_ready (rq_ready),
        .req       (s2_req_reg),
        .cfg       (rq_cfg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (rq_result)
    );

    assign result = $signed(rq_result);

endmodule

FILE: rtl/fcmr_checker.sv
// ----------------------------------------------------------------------------
// fcmr_checker
// Port-level checks for the int8 fully connected MAC block, attached by bind.
// ----------------------------------------------------------------------------
module fcmr_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [fcmr_pkg::BYTE_W-1:0]  result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fcmr_pkg::ADDR_W-1:0]         paddr,
    input  logic [fcmr_pkg::DATA_W-1:0]         pwdata,
    input  logic [fcmr_pkg::DATA_W-1:0]         prdata,
    input  logic                                pready
);
    import fcmr_pkg::*;

    // a pending result holds until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(result))
        else $error("result changed while stalled");

    // with the output register empty the whole pipeline can move
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a register read right after a write returns the written byte
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && $past(rst_n) && $past(psel && penable && pwrite && pready)
        && (paddr[ADDR_W-1:2] == $past(paddr[ADDR_W-1:2]))
        |-> (prdata == DATA_W'($past(pwdata[BYTE_W-1:0]))))
        else $error("config readback mismatch");

endmodule

bind int8_fully_connected_mac_requant fcmr_checker u_fcmr_checker (.*);

FILE: tb/fcmr_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcmr_result_checker
// Watches the input, output and configuration channels of the int8 fully
// connected MAC block. Keeps its own accumulator and register copies, predicts
// each requantized output byte and compares it with what the block delivers.
// ----------------------------------------------------------------------------
module fcmr_result_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [fcmr_pkg::LANE_DATA_W-1:0]    act_lanes,
    input  logic [fcmr_pkg::LANE_DATA_W-1:0]    weight_lanes,
    input  logic [fcmr_pkg::LANES_USED_W-1:0]   lanes_used,
    input  logic                                first,
    input  logic                                last,
    input  logic signed [fcmr_pkg::ACC_W-1:0]   bias,
    input  logic [fcmr_pkg::MULT_W-1:0]         scale_mult,
    input  logic [fcmr_pkg::SHIFT_W-1:0]        scale_shift,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [fcmr_pkg::BYTE_W-1:0]  result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fcmr_pkg::ADDR_W-1:0]         paddr,
    input  logic [fcmr_pkg::DATA_W-1:0]         pwdata,
    input  logic [fcmr_pkg::DATA_W-1:0]         prdata,
    input  logic                                pready,
    output int                                  fail_count,
    output int                                  outputs_due,
    output int                                  items_seen,
    output int                                  results_seen
);
    import fcmr_pkg::*;

    logic signed [BYTE_W-1:0] act_zero_sh;
    logic signed [BYTE_W-1:0] out_zero_sh;
    logic signed [BYTE_W-1:0] clamp_low_sh;
    logic signed [BYTE_W-1:0] clamp_high_sh;
    logic [ACC_W-1:0]         acc_model;
    logic signed [BYTE_W-1:0] result_due_q[$];
    int                       err_tally;
    int                       n_items;
    int                       n_results;

    // sum of (a - zero point) * w over the used lanes, wrapping at 32 bits
    function automatic logic [ACC_W-1:0] lane_dot(
        logic [LANE_DATA_W-1:0]   acts,
        logic [LANE_DATA_W-1:0]   wts,
        logic [LANES_USED_W-1:0]  n_used,
        logic signed [BYTE_W-1:0] zp
    );
        int               n;
        int               i;
        int               a;
        int               w;
        logic [ACC_W-1:0] sum;
        n   = (n_used > LANES) ? LANES : int'(n_used);
        sum = '0;
        for (i = 0; i < n; i++)
        begin
            a   = int'($signed(acts[8*i +: 8])) - int'(zp);
            w   = int'($signed(wts[8*i +: 8]));
            sum = sum + ACC_W'(a * w);
        end
        return sum;
    endfunction

    function automatic logic signed [BYTE_W-1:0] requant_out(
        logic [ACC_W-1:0]         acc,
        logic [MULT_W-1:0]        mult,
        logic [SHIFT_W-1:0]       shift,
        logic signed [BYTE_W-1:0] oz,
        logic signed [BYTE_W-1:0] lo,
        logic signed [BYTE_W-1:0] hi
    );
        logic        neg;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] q;
        int          s;
        longint      v;
        neg  = acc[ACC_W-1];
        mag  = neg ? ({32'd0, ~acc} + 64'd1) : {32'd0, acc};
        prod = mag * {33'd0, mult};
        s    = 31 + int'(shift);
        // round half away from zero on the magnitude
        if (s >= 64)
            q = '0;
        else
            q = (prod + (64'd1 << (s - 1))) >> s;
        v = longint'(q);
        if (neg)
            v = -v;
        v = v + longint'(oz);
        if (v < OUT_MIN)
            v = OUT_MIN;
        if (v > OUT_MAX)
            v = OUT_MAX;
        if (v < lo)
            v = longint'(lo);
        if (v > hi)
            v = longint'(hi);
        return v[BYTE_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] reg_value(cfg_reg_t r);
        case (r)
            REG_ACT_ZERO:   return act_zero_sh;
            REG_OUT_ZERO:   return out_zero_sh;
            REG_CLAMP_LOW:  return clamp_low_sh;
            default:        return clamp_high_sh;
        endcase
    endfunction

    always @(posedge clk)
    begin
        logic signed [BYTE_W-1:0] want;
        cfg_reg_t                 idx;
        if (!rst_n)
        begin
            act_zero_sh   = ACT_ZERO_RST;
            out_zero_sh   = OUT_ZERO_RST;
            clamp_low_sh  = CLAMP_LOW_RST;
            clamp_high_sh = CLAMP_HIGH_RST;
            acc_model     = '0;
            result_due_q.delete();
            err_tally     = 0;
            n_items       = 0;
            n_results     = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                idx = cfg_reg_t'(paddr[3:2]);
                if (pwrite)
                begin
                    case (idx)
                        REG_ACT_ZERO:   act_zero_sh   = pwdata[BYTE_W-1:0];
                        REG_OUT_ZERO:   out_zero_sh   = pwdata[BYTE_W-1:0];
                        REG_CLAMP_LOW:  clamp_low_sh  = pwdata[BYTE_W-1:0];
                        default:        clamp_high_sh = pwdata[BYTE_W-1:0];
                    endcase
                end
                else if (prdata[BYTE_W-1:0] !== reg_value(idx))
                begin
                    $error("prdata: expected %0h, actual %0h", reg_value(idx),
                           prdata[BYTE_W-1:0]);
                    err_tally++;
                end
            end

            // retire the output side first so a same-edge push is not paired
            if (out_valid && out_ready)
            begin
                n_results++;
                if (result_due_q.size() == 0)
                begin
                    $error("result: expected none, actual %0d", result);
                    err_tally++;
                end
                else
                begin
                    want = result_due_q.pop_front();
                    if (result !== want)
                    begin
                        $error("result: expected %0d, actual %0d", want, result);
                        err_tally++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                n_items++;
                if (first)
                    acc_model = bias;
                acc_model = acc_model + lane_dot(act_lanes, weight_lanes, lanes_used,
                                                 act_zero_sh);
                if (last)
                    result_due_q.push_back(requant_out(acc_model, scale_mult, scale_shift,
                                                       out_zero_sh, clamp_low_sh,
                                                       clamp_high_sh));
            end
        end
        fail_count   <= err_tally;
        outputs_due  <= result_due_q.size();
        items_seen   <= n_items;
        results_seen <= n_results;
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the int8 fully connected MAC and requantization block: a
// directed set of corner items, then random channels under several register
// settings, with random gaps and output back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import fcmr_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 11;
    localparam int DRAIN_CYCLES     = 16;
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 235;
    localparam int IDLE_PCT         = 31;

    typedef struct {
        logic [LANE_DATA_W-1:0]  acts;
        logic [LANE_DATA_W-1:0]  wgts;
        logic [LANES_USED_W-1:0] n_lanes;
        logic                    is_first;
        logic                    is_last;
        logic [ACC_W-1:0]        bias_v;
        logic [MULT_W-1:0]       mult;
        logic [SHIFT_W-1:0]      shift;
    } fc_item_t;

    typedef struct {
        logic signed [BYTE_W-1:0] act_zero;
        logic signed [BYTE_W-1:0] out_zero;
        logic signed [BYTE_W-1:0] clamp_low;
        logic signed [BYTE_W-1:0] clamp_high;
    } cfg_set_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [LANE_DATA_W-1:0]     act_lanes;
    logic [LANE_DATA_W-1:0]     weight_lanes;
    logic [LANES_USED_W-1:0]    lanes_used;
    logic                       first;
    logic                       last;
    logic signed [ACC_W-1:0]    bias;
    logic [MULT_W-1:0]          scale_mult;
    logic [SHIFT_W-1:0]         scale_shift;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [BYTE_W-1:0]   result;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       no_idle;
    int                         fail_count;
    int                         outputs_due;
    int                         items_seen;
    int                         results_seen;
    int                         settings_used;

    int8_fully_connected_mac_requant DUT (.*);

    fcmr_result_checker u_checker (.*);

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

    function automatic fc_item_t make_item(
        logic [31:0] acts, logic [31:0] wgts, logic [2:0] n, logic f, logic l,
        logic [31:0] b, logic [30:0] m, logic [5:0] s
    );
        fc_item_t it;
        it.acts     = acts;
        it.wgts     = wgts;
        it.n_lanes  = n;
        it.is_first = f;
        it.is_last  = l;
        it.bias_v   = b;
        it.mult     = m;
        it.shift    = s;
        return it;
    endfunction

    function automatic fc_item_t rand_item();
        fc_item_t it;
        int       pick;
        it.acts    = $urandom;
        it.wgts    = $urandom;
        it.n_lanes = LANES_USED_W'(($urandom_range(99) < 85) ? $urandom_range(1, LANES)
                                                             : $urandom_range(0, 7));
        pick = $urandom_range(3);
        case (pick)
            0, 1:    it.bias_v = $urandom_range(0, 131071) - 65536;
            2:       it.bias_v = $urandom;
            default: it.bias_v = ($urandom_range(1) ? 32'h7FFF_0000 : 32'h8000_0000)
                                 + $urandom_range(0, 65535);
        endcase
        it.mult = MULT_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)
            it.shift = SHIFT_W'($urandom_range(0, 12));
        else if (pick < 90)
            it.shift = SHIFT_W'($urandom_range(13, 40));
        else
            it.shift = SHIFT_W'($urandom_range(41, 63));
        it.is_first = 1'b0;
        it.is_last  = 1'b0;
        return it;
    endfunction

    function automatic cfg_set_t phase_cfg(int p);
        cfg_set_t c;
        case (p)
            1:       c = '{-8'sd128, 8'sd127, -8'sd128, 8'sd127};
            2:       c = '{8'sd127, -8'sd128, -8'sd128, 8'sd127};
            3:       c = '{8'sd3, -8'sd5, -8'sd5, 8'sd37};     // relu6 style
            4:       c = '{-8'sd20, 8'sd10, 8'sd60, -8'sd40};  // crossed bounds
            5:       c = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
            6:       c = '{8'sd0, 8'sd0, 8'sd127, 8'sd127};
            default: c = '{8'sd1, -8'sd1, -8'sd128, -8'sd128};
        endcase
        return c;
    endfunction

    task automatic apb_transfer(input logic wr, input cfg_reg_t r, input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {r, 2'b00};
        pwdata  <= {{24{v[7]}}, v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_cfg(input cfg_set_t c);
        apb_transfer(1'b1, REG_ACT_ZERO, c.act_zero);
        apb_transfer(1'b1, REG_OUT_ZERO, c.out_zero);
        apb_transfer(1'b1, REG_CLAMP_LOW, c.clamp_low);
        apb_transfer(1'b1, REG_CLAMP_HIGH, c.clamp_high);
        apb_transfer(1'b0, REG_ACT_ZERO, 8'h00);
        apb_transfer(1'b0, REG_OUT_ZERO, 8'h00);
        apb_transfer(1'b0, REG_CLAMP_LOW, 8'h00);
        apb_transfer(1'b0, REG_CLAMP_HIGH, 8'h00);
    endtask

    // valid stays high between back-to-back items, drops only for a gap
    task automatic send_item(input fc_item_t it);
        while (!no_idle && ($urandom_range(99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        act_lanes    <= it.acts;
        weight_lanes <= it.wgts;
        lanes_used   <= it.n_lanes;
        first        <= it.is_first;
        last         <= it.is_last;
        bias         <= it.bias_v;
        scale_mult   <= it.mult;
        scale_shift  <= it.shift;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outputs_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int n_items);
        int       sent;
        int       kind;
        int       len;
        int       k;
        fc_item_t it;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 78)
            begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++)
                begin
                    it = rand_item();
                    it.is_first = (k == 0);
                    it.is_last  = (k == len - 1);
                    send_item(it);
                    sent++;
                end
            end
            else if (kind < 90)
            begin
                it = rand_item();
                it.is_first = 1'($urandom_range(1));
                it.is_last  = 1'($urandom_range(1));
                send_item(it);
                sent++;
            end
            else
            begin
                // channel that is cut off and later restarted by a new first
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                begin
                    it = rand_item();
                    it.is_first = (k == 0);
                    send_item(it);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        fc_item_t directed[$];
        int       p;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        act_lanes    <= '0;
        weight_lanes <= '0;
        lanes_used   <= '0;
        first        <= 1'b0;
        last         <= 1'b0;
        bias         <= '0;
        scale_mult   <= '0;
        scale_shift  <= '0;
        out_ready    <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        no_idle      <= 1'b0;
        settings_used = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // saturation at both ends
        directed.push_back(make_item(32'h7F7F7F7F, 32'h7F7F7F7F, 4, 1, 1, 0, 31'h7FFFFFFF, 0));
        directed.push_back(make_item(32'h80808080, 32'h7F7F7F7F, 4, 1, 1, 0, 31'h7FFFFFFF, 0));
        directed.push_back(make_item(32'h80808080, 32'h80808080, 4, 1, 1, 0, 31'h7FFFFFFF, 14));
        directed.push_back(make_item(32'h000000FF, 32'h00000080, 1, 1, 1, 0, 31'h7FFFFFFF, 0));
        // rounding ties with a half multiplier, zero lanes
        directed.push_back(make_item(32'h0, 32'h0, 0, 1, 1, -3, 31'h40000000, 0));
        directed.push_back(make_item(32'h0, 32'h0, 0, 1, 1, 3, 31'h40000000, 0));
        directed.push_back(make_item(32'h0, 32'h0, 0, 1, 1, 5, 31'h40000000, 0));
        directed.push_back(make_item(32'hFFFFFFFF, 32'hFFFFFFFF, 0, 1, 1, -1, 31'h40000000, 0));
        // lane counts above the lane array
        directed.push_back(make_item(32'h01020304, 32'h7F80017F, 5, 1, 1, 0, 31'h7FFFFFFF, 0));
        directed.push_back(make_item(32'h8081FE7F, 32'h7F80017F, 7, 1, 1, 0, 31'h7FFFFFFF, 8));
        // accumulator wrap across items
        directed.push_back(make_item(32'h0, 32'h0, 0, 1, 0, 32'h7FFFFFFF, 0, 0));
        directed.push_back(make_item(32'h7F7F7F7F, 32'h7F7F7F7F, 4, 0, 0, 0, 0, 0));
        directed.push_back(make_item(32'h0, 32'h0, 1, 0, 1, 0, 31'h7FFFFFFF, 24));
        // last without first keeps the running total
        directed.push_back(make_item(32'h01010101, 32'hFFFFFFFF, 4, 0, 1, 123, 31'h7FFFFFFF, 24));
        // most negative accumulator against large shifts
        directed.push_back(make_item(32'h0, 32'h0, 0, 1, 1, 32'h80000000, 31'h7FFFFFFF, 31));
        directed.push_back(make_item(32'h0, 32'h0, 0, 1, 1, 32'h80000000, 31'h7FFFFFFF, 32));
        directed.push_back(make_item(32'h0, 32'h0, 0, 1, 1, 32'h80000000, 31'h7FFFFFFF, 62));
        directed.push_back(make_item(32'h0, 32'h0, 0, 1, 1, 32'h80000000, 31'h7FFFFFFF, 63));
        directed.push_back(make_item(32'hAAAAAAAA, 32'h55555555, 4, 1, 1, 12345, 0, 0));
        directed.push_back(make_item(32'h0, 32'h0, 0, 1, 1, 32'h7FFFFFFF, 31'h7FFFFFFF, 0));
        // plain multi-item channel
        directed.push_back(make_item(32'h12345678, 32'h9ABCDEF0, 4, 1, 0, 100, 0, 0));
        directed.push_back(make_item(32'hFEDCBA98, 32'h76543210, 3, 0, 0, 0, 0, 0));
        directed.push_back(make_item(32'h00FF807F, 32'h7F80FF01, 2, 0, 1, 0, 31'h55555555, 9));
        foreach (directed[i])
            send_item(directed[i]);
        wait_idle();

        for (p = 0; p < PHASES; p++)
        begin
            if (p > 0)
                apply_cfg(phase_cfg(p));
            // one whole phase with neither side idling
            no_idle <= (p == 2);
            run_random(ITEMS_PER_PHASE);
            wait_idle();
            settings_used++;
        end

        $display("covered %0d input transfers and %0d results over %0d register settings",
                 items_seen, results_seen, settings_used);
        $display("incl. lane counts 0 to 7, accumulator wrap, rounding ties, crossed clamps");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("run timed out");
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
rtl/fcmr_pkg.sv
rtl/fcmr_lane.sv
rtl/fcmr_requant.sv
rtl/int8_fully_connected_mac_requant.sv
rtl/fcmr_checker.sv
tb/fcmr_result_checker.sv
tb/tb.sv
